FILE: hw/rtl/xcrc_pkg.sv
// Shared constants, result type and CRC-16 byte update for the XMODEM-CRC receiver.
package xcrc_pkg;

    localparam int DATA_BYTES = 128;

    // The frame position counts from zero up to DATA_BYTES + 4.
    localparam int POS_W = $clog2(DATA_BYTES + 5);

    localparam logic [7:0] CODE_SOH = 8'h01;
    localparam logic [7:0] CODE_EOT = 8'h04;
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    localparam int TDATA_W = 32;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] reply_byte;
        logic       block_good;
        logic       transfer_done;
        logic [7:0] block_number;
    } result_t;

    // One byte through CRC-16/XMODEM, MSB first; unrolls to an XOR network.
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/xcrc_parser.sv
// Frame parser: tracks the frame position, header checks and running CRC for one byte a cycle while step is high.
module xcrc_parser
    import xcrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_NUM    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CMPL   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(3 + DATA_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       expected_reg, expected_next;
    logic [15:0]      crc_reg, crc_next;
    logic             header_good_reg, header_good_next;
    logic [7:0]       crc_high_reg, crc_high_next;
    logic             finished_reg, finished_next;

    logic             good;

    always_comb begin
        pos_next         = pos_reg;
        expected_next    = expected_reg;
        crc_next         = crc_reg;
        header_good_next = header_good_reg;
        crc_high_next    = crc_high_reg;
        finished_next    = finished_reg;
        res_valid        = 1'b0;
        res              = '0;
        res.block_number = expected_reg;
        good             = header_good_reg && ({crc_high_reg, rx_byte} == crc_reg);

        if (step && !finished_reg) begin
            if (pos_reg == POS_START) begin
                if (rx_byte == CODE_EOT) begin
                    finished_next     = 1'b1;
                    res_valid         = 1'b1;
                    res.kind          = KIND_REPLY;
                    res.reply_byte    = CODE_ACK;
                    res.transfer_done = 1'b1;
                end else begin
                    header_good_next = (rx_byte == CODE_SOH);
                    crc_next         = 16'h0000;
                    pos_next         = POS_NUM;
                end
            end else if (pos_reg == POS_NUM) begin
                if (rx_byte != expected_reg) begin
                    header_good_next = 1'b0;
                end
                pos_next = POS_CMPL;
            end else if (pos_reg == POS_CMPL) begin
                if (rx_byte != ~expected_reg) begin
                    header_good_next = 1'b0;
                end
                pos_next = pos_reg + POS_W'(1);
            end else if (pos_reg < POS_CRC_HI) begin
                crc_next         = crc_update(crc_reg, rx_byte);
                pos_next         = pos_reg + POS_W'(1);
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
            end else if (pos_reg == POS_CRC_HI) begin
                crc_high_next = rx_byte;
                pos_next      = pos_reg + POS_W'(1);
            end else begin
                pos_next         = POS_START;
                crc_next         = 16'h0000;
                header_good_next = 1'b0;
                crc_high_next    = 8'h00;
                if (good) begin
                    expected_next = expected_reg + 8'd1;
                end
                res_valid      = 1'b1;
                res.kind       = KIND_REPLY;
                res.reply_byte = good ? CODE_ACK : CODE_NAK;
                res.block_good = good;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= POS_START;
            expected_reg    <= 8'd1;
            crc_reg         <= 16'h0000;
            header_good_reg <= 1'b0;
            crc_high_reg    <= 8'h00;
            finished_reg    <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            expected_reg    <= expected_next;
            crc_reg         <= crc_next;
            header_good_reg <= header_good_next;
            crc_high_reg    <= crc_high_next;
            finished_reg    <= finished_next;
        end
    end

endmodule

FILE: hw/rtl/xcrc_out_reg.sv
// Result register driving the master-side stream, with the stall signal for the stage before it.
module xcrc_out_reg
    import xcrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic               res_valid,
    input  result_t            res,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // payload_byte, reply_byte, block_good, transfer_done, block_number
    output logic               m_tuser   // kind
);

    logic    valid_reg;
    result_t res_reg;

    // The register can take a new beat when empty or when its beat leaves this cycle.
    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {6'b000000, res_reg.block_number, res_reg.transfer_done,
                       res_reg.block_good, res_reg.reply_byte, res_reg.payload_byte};

endmodule

FILE: hw/rtl/xmodem_crc_block_receiver_top.sv
// Top level of the XMODEM-CRC block receiver: input register, frame parser, result register.
//
// Received serial bytes enter on the slave stream, one byte per beat in s_tdata[7:0].
// Each frame is start byte, block number, its complement, DATA_BYTES payload bytes and
// a big-endian CRC-16. Every payload byte leaves on the master stream as tentative data
// (m_tuser low); the last CRC byte gives one reply beat (m_tuser high) carrying ACK or NAK.
// An EOT in the start position is answered with ACK and transfer_done, and every later
// byte is dropped until reset. Header bytes and the first CRC byte give no output beat.
// Throughput is one byte per cycle while m_tready does not stall: the CRC update is a
// combinational XOR network between the input register and the result register. A byte waits in
// the input register and its result in the result register, which drives m_tvalid. When the sink
// holds m_tready low, the result register holds its beat and the input register holds one more
// byte, then s_tready drops; no beat is lost. Reset (aresetn low, synchronous) empties both
// registers, sets the expected block number to 1 and returns the parser to the start position.
module xmodem_crc_block_receiver_top
    import xcrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // payload_byte, reply_byte, block_good, transfer_done, block_number
    output logic               m_tuser    // kind
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       can_load;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // The buffered byte moves through the parser once the result register can take it.
    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    xcrc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    xcrc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
